// ===== hdl/word_hash_double_hash_insert_defines.svh =====
// assertion macros for the document hash table block
`ifndef WORD_HASH_DOUBLE_HASH_INSERT_DEFINES_SVH
`define WORD_HASH_DOUBLE_HASH_INSERT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define WHD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define WHD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/whdh_pkg.sv =====
// shared constants, types and helpers for the document hash table block
package whdh_pkg;

  localparam int TABLE_SIZE = 11;
  localparam int MAX_LEN    = 1024;
  localparam int HASH_BASE  = 31;

  localparam int KEY_W     = 32;
  localparam int SLOT_W    = $clog2(TABLE_SIZE);
  localparam int LEN_W     = $clog2(MAX_LEN + 1);
  localparam int IDX_W     = $clog2(MAX_LEN);
  localparam int SADDR_W   = $clog2(TABLE_SIZE * MAX_LEN);
  localparam int ACC_W     = $clog2(TABLE_SIZE * 16);
  localparam int MOD_STEPS = KEY_W / 4;
  localparam int MOD_CNT_W = $clog2(MOD_STEPS);
  localparam int PRB_W     = $clog2(TABLE_SIZE + 1);

  localparam logic [7:0] SPACE_BYTE = 8'h20;

  typedef enum logic [1:0] {
    STAT_INSERTED  = 2'd0,
    STAT_DUPLICATE = 2'd1,
    STAT_FULL      = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MOD,
    ST_HOME,
    ST_PROBE,
    ST_CMP_RD,
    ST_CMP_CHK,
    ST_CPY_RD,
    ST_CPY_WR,
    ST_COMMIT,
    ST_NEXT
  } ctrl_state_t;

  typedef struct packed {
    logic    take;
    logic    mod_step;
    logic    home_add;
    logic    cnt_clr;
    logic    rd;
    logic    cnt_inc;
    logic    wr;
    logic    commit;
    logic    next_probe;
    logic    emit;
    status_t emit_status;
  } cmd_t;

  typedef struct packed {
    logic word_end;
    logic mod_last;
    logic last_doc;
    logic slot_free;
    logic len_match;
    logic len_zero;
    logic cnt_last;
    logic byte_eq;
    logic probes_done;
  } stat_t;

  // one nibble of a remainder by restoring subtraction, r below dvs
  function automatic logic [SLOT_W-1:0] rem_step(input logic [SLOT_W-1:0] r,
                                                 input logic [3:0] nib,
                                                 input logic [SLOT_W-1:0] dvs);
    logic [ACC_W-1:0] acc;
    acc = (ACC_W'(r) << 4) | ACC_W'(nib);
    for (int k = 3; k >= 0; k--) begin
      if (acc >= (ACC_W'(dvs) << k)) begin
        acc = acc - (ACC_W'(dvs) << k);
      end
    end
    return SLOT_W'(acc);
  endfunction

endpackage

// ===== hdl/word_hash_double_hash_insert.sv =====
// top level of the document hash table with double-hashing insert
// A document enters one byte per transaction (start while busy is low). A byte
// inside a word is taken while the controller stays idle. A space or the last
// byte closes a word: the 32-bit word key is reduced mod 11 and mod 10 a nibble
// per cycle, and the mod 11 remainder is added to the home index. On the last
// byte the controller then probes: each slot visit checks the slot, compares the
// stored bytes one by one (read, then check) when lengths match, and steps to the
// next probe when the slot holds other content; an insert copies the staged
// content byte by byte (read, then write) into the single-port slot memory, then
// commits. The registered result shows in the cycle after the deciding state.
// The result appears on out_status/out_slot for one cycle with
// out_strobe high and must be taken then; the receiver cannot stall.
// No clearing pass follows reset: only the 11 slot valid bits are cleared.
module word_hash_double_hash_insert (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [7:0] in_content_byte,
  input  logic       in_last_byte,
  input  logic       in_new_table,
  output logic       out_strobe,
  output logic [1:0] out_status,
  output logic [3:0] out_slot
);
  import whdh_pkg::*;
  `include "word_hash_double_hash_insert_defines.svh"

  cmd_t  cmd;
  stat_t stat;

  // sequencing of hash, probe, compare and copy
  whdh_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  // key arithmetic, stores and result register
  whdh_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_content_byte (in_content_byte),
    .in_last_byte    (in_last_byte),
    .in_new_table    (in_new_table),
    .cmd             (cmd),
    .stat            (stat),
    .out_strobe      (out_strobe),
    .out_status      (out_status),
    .out_slot        (out_slot)
  );

  // a full table reports slot zero
  `WHD_ASSERT_NOW(a_full_slot, out_strobe && out_status == STAT_FULL, out_slot == 4'd0, "full result with nonzero slot")
  // a result is shown only once the controller is back to idle
  `WHD_ASSERT_NOW(a_strobe_idle, out_strobe, !busy, "result strobe while busy")
  // a byte inside the document never yields a result
  `WHD_ASSERT_NEXT(a_no_early, start && !busy && !in_last_byte, !out_strobe, "result without last byte")
  // one result per document transaction
  `WHD_ASSERT_NEXT(a_single, out_strobe, !out_strobe, "back to back result strobes")

endmodule

// ===== hdl/whdh_ctrl.sv =====
// controller state machine sequencing hashing, probing, compare and copy
module whdh_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  whdh_pkg::stat_t stat,
  output whdh_pkg::cmd_t  cmd,
  output logic          busy
);
  import whdh_pkg::*;

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start && stat.word_end) state_nxt = ST_MOD;
      end
      ST_MOD: begin
        if (stat.mod_last) state_nxt = ST_HOME;
      end
      ST_HOME: begin
        state_nxt = stat.last_doc ? ST_PROBE : ST_IDLE;
      end
      ST_PROBE: begin
        if (stat.slot_free) begin
          state_nxt = stat.len_zero ? ST_COMMIT : ST_CPY_RD;
        end else if (stat.len_match) begin
          state_nxt = stat.len_zero ? ST_IDLE : ST_CMP_RD;
        end else begin
          state_nxt = ST_NEXT;
        end
      end
      ST_CMP_RD:  state_nxt = ST_CMP_CHK;
      ST_CMP_CHK: begin
        if (!stat.byte_eq) state_nxt = ST_NEXT;
        else if (stat.cnt_last) state_nxt = ST_IDLE;
        else state_nxt = ST_CMP_RD;
      end
      ST_CPY_RD: state_nxt = ST_CPY_WR;
      ST_CPY_WR: state_nxt = stat.cnt_last ? ST_COMMIT : ST_CPY_RD;
      ST_COMMIT: state_nxt = ST_IDLE;
      ST_NEXT:   state_nxt = stat.probes_done ? ST_IDLE : ST_PROBE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd             = '0;
    cmd.emit_status = STAT_INSERTED;
    busy            = (state_r != ST_IDLE);
    case (state_r)
      ST_IDLE:  cmd.take = start;
      ST_MOD:   cmd.mod_step = 1'b1;
      ST_HOME:  cmd.home_add = 1'b1;
      ST_PROBE: begin
        cmd.cnt_clr = 1'b1;
        if (!stat.slot_free && stat.len_match && stat.len_zero) begin
          cmd.emit        = 1'b1;
          cmd.emit_status = STAT_DUPLICATE;
        end
      end
      ST_CMP_RD:  cmd.rd = 1'b1;
      ST_CMP_CHK: begin
        if (stat.byte_eq && stat.cnt_last) begin
          cmd.emit        = 1'b1;
          cmd.emit_status = STAT_DUPLICATE;
        end else if (stat.byte_eq) begin
          cmd.cnt_inc = 1'b1;
        end
      end
      ST_CPY_RD: cmd.rd = 1'b1;
      ST_CPY_WR: begin
        cmd.wr      = 1'b1;
        cmd.cnt_inc = 1'b1;
      end
      ST_COMMIT: begin
        cmd.commit      = 1'b1;
        cmd.emit        = 1'b1;
        cmd.emit_status = STAT_INSERTED;
      end
      ST_NEXT: begin
        if (stat.probes_done) begin
          cmd.emit        = 1'b1;
          cmd.emit_status = STAT_FULL;
        end else begin
          cmd.next_probe = 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== hdl/whdh_dp.sv =====
// datapath: key hashing, remainder unit, probe index, stores and result register
module whdh_dp (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [7:0]    in_content_byte,
  input  logic          in_last_byte,
  input  logic          in_new_table,
  input  whdh_pkg::cmd_t  cmd,
  output whdh_pkg::stat_t stat,
  output logic          out_strobe,
  output logic [1:0]    out_status,
  output logic [3:0]    out_slot
);
  import whdh_pkg::*;

  localparam logic [SLOT_W-1:0] TS_C   = SLOT_W'(TABLE_SIZE);
  localparam logic [SLOT_W-1:0] STEP_C = SLOT_W'(TABLE_SIZE - 1);

  logic [KEY_W-1:0]     word_key_r, key_nxt, mod_key_r;
  logic [LEN_W-1:0]     stage_len_r, cnt_r;
  logic [SLOT_W-1:0]    home_r, home_nxt, r11_r, r10_r, idx_r, base_r, step_r;
  logic [SLOT_W:0]      home_sum, idx_sum;
  logic [MOD_CNT_W-1:0] mod_cnt_r;
  logic [PRB_W-1:0]     m_r;
  logic                 last_r, space_r;
  logic [TABLE_SIZE-1:0] slot_valid_r;
  logic [LEN_W-1:0]     slot_len_r [TABLE_SIZE];
  logic [7:0]           stage_mem [MAX_LEN];
  logic [7:0]           slot_mem [TABLE_SIZE * MAX_LEN];
  logic [7:0]           stage_rd_r, slot_rd_r;
  logic [SADDR_W-1:0]   slot_addr;
  logic                 out_strobe_r;
  status_t              out_status_r;
  logic [SLOT_W-1:0]    out_slot_r;

  assign key_nxt   = word_key_r * KEY_W'(HASH_BASE) + KEY_W'(in_content_byte);
  assign home_sum  = {1'b0, home_r} + {1'b0, r11_r};
  assign home_nxt  = (home_sum >= {1'b0, TS_C}) ? SLOT_W'(home_sum - {1'b0, TS_C})
                                                : SLOT_W'(home_sum);
  assign idx_sum   = (m_r == '0) ? {1'b0, base_r} + {1'b0, step_r}
                                 : {1'b0, idx_r} + {1'b0, step_r};
  assign slot_addr = SADDR_W'(idx_r) * SADDR_W'(MAX_LEN) + SADDR_W'(cnt_r);

  always_comb begin
    stat.word_end    = (in_content_byte == SPACE_BYTE) || in_last_byte;
    stat.mod_last    = (mod_cnt_r == MOD_CNT_W'(MOD_STEPS - 1));
    stat.last_doc    = last_r;
    stat.slot_free   = !slot_valid_r[idx_r];
    stat.len_match   = (slot_len_r[idx_r] == stage_len_r);
    stat.len_zero    = (stage_len_r == '0);
    stat.cnt_last    = ((cnt_r + LEN_W'(1)) == stage_len_r);
    stat.byte_eq     = (stage_rd_r == slot_rd_r);
    stat.probes_done = (m_r == PRB_W'(TABLE_SIZE));
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_len_r  <= '0;
      word_key_r   <= '0;
      home_r       <= '0;
      slot_valid_r <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= cmd.emit;
      if (cmd.take) begin
        if (in_new_table) slot_valid_r <= '0;
        if (stage_len_r < LEN_W'(MAX_LEN)) stage_len_r <= stage_len_r + LEN_W'(1);
        word_key_r <= (in_content_byte == SPACE_BYTE) ? '0 : key_nxt;
      end
      if (cmd.home_add) home_r <= home_nxt;
      if (cmd.commit) slot_valid_r[idx_r] <= 1'b1;
      if (cmd.emit) begin
        stage_len_r <= '0;
        word_key_r  <= '0;
        home_r      <= '0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      mod_key_r <= key_nxt;
      r11_r     <= '0;
      r10_r     <= '0;
      mod_cnt_r <= '0;
      last_r    <= in_last_byte;
      space_r   <= (in_content_byte == SPACE_BYTE);
    end
    if (cmd.mod_step) begin
      r11_r     <= rem_step(r11_r, mod_key_r[KEY_W-1 -: 4], TS_C);
      r10_r     <= rem_step(r10_r, mod_key_r[KEY_W-1 -: 4], STEP_C);
      mod_key_r <= mod_key_r << 4;
      mod_cnt_r <= mod_cnt_r + MOD_CNT_W'(1);
    end
    if (cmd.home_add) begin
      idx_r  <= home_nxt;
      m_r    <= '0;
      base_r <= space_r ? '0 : r11_r;
      step_r <= space_r ? SLOT_W'(1) : r10_r + SLOT_W'(1);
    end
    if (cmd.next_probe) begin
      idx_r <= (idx_sum >= {1'b0, TS_C}) ? SLOT_W'(idx_sum - {1'b0, TS_C})
                                         : SLOT_W'(idx_sum);
      m_r   <= m_r + PRB_W'(1);
    end
    if (cmd.cnt_clr) cnt_r <= '0;
    if (cmd.cnt_inc) cnt_r <= cnt_r + LEN_W'(1);
    if (cmd.commit) slot_len_r[idx_r] <= stage_len_r;
    if (cmd.emit) begin
      out_status_r <= cmd.emit_status;
      out_slot_r   <= (cmd.emit_status == STAT_FULL) ? '0 : idx_r;
    end
  end

  // staged content and slot content memories
  always_ff @(posedge clk) begin
    if (cmd.take && stage_len_r < LEN_W'(MAX_LEN)) begin
      stage_mem[stage_len_r[IDX_W-1:0]] <= in_content_byte;
    end
    if (cmd.rd) begin
      stage_rd_r <= stage_mem[cnt_r[IDX_W-1:0]];
      slot_rd_r  <= slot_mem[slot_addr];
    end
    if (cmd.wr) slot_mem[slot_addr] <= stage_rd_r;
  end

  assign out_strobe = out_strobe_r;
  assign out_status = out_status_r;
  assign out_slot   = 4'(out_slot_r);

endmodule
